### hw/rtl/rtcm3fc_pkg.sv
// shared types, constants and the crc-24q byte update for the rtcm3 frame checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rtcm3fc_pkg;

   localparam logic [7:0]  RTCM_PREAMBLE = 8'hD3;
   localparam logic [23:0] CRC24Q_POLY   = 24'h864CFB;   // low 24 bits of 0x1864CFB
   localparam logic [10:0] MAX_FRAME_RST = 11'd1029;
   localparam logic [10:0] FRAME_OVERHEAD = 11'd6;

   localparam logic [1:0] STATUS_GOOD    = 2'd0;
   localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
   localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

   typedef struct packed {
      logic [15:0] crc_error_count;
      logic [15:0] good_frame_count;
      logic [23:0] computed_crc;
      logic [23:0] received_crc;
      logic [11:0] message_number;
      logic [9:0]  payload_length;
      logic [1:0]  frame_status;
   } rsp_type;

   // msb-first crc-24q over one byte, unrolled
   function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
      logic [23:0] c;
      c = crc ^ {b, 16'h0000};
      for (int i = 0; i < 8; i++) begin
         if (c[23]) begin
            c = {c[22:0], 1'b0} ^ CRC24Q_POLY;
         end else begin
            c = {c[22:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/rtcm3_frame_checker.sv
// rtcm3 frame checker top level: byte-stream parser, crc-24q check, result buffer
// depends on rtcm3fc_pkg
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per beat on req_ and reports one result beat per frame on rsp_:
// good frame, crc mismatch, or a length plus FRAME_OVERHEAD beyond max_frame_bytes. The
// parser state and the crc-24q update (eight unrolled shift steps) sit between the input
// handshake and a result register, so a byte can follow in every cycle while req_tready is
// high. The result of the byte that ends a frame is registered into the output slot, or,
// while one result waits there, into a second slot that keeps req_tready high; only when
// both slots are full does req_tready drop. max_frame_bytes resets to 1029.
module rtcm3_frame_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [10:0]            csr_wdata,    // max_frame_bytes
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [7:0]             req_tdata,    // rx_byte
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [1:0]             rsp_tuser,    // frame_status
   // payload_length, message_number, received_crc, computed_crc,
   // good_frame_count, crc_error_count, 2 zero bits
   output      logic [103:0]           rsp_tdata
);
   import rtcm3fc_pkg::*;

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_LEN_HI  = 3'd1;
   localparam logic [2:0] PH_LEN_LO  = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_CRC1    = 3'd4;
   localparam logic [2:0] PH_CRC2    = 3'd5;
   localparam logic [2:0] PH_CRC3    = 3'd6;

   logic [10:0] max_frame_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [23:0] crc_ff, crc_in;
   logic [23:0] trailer_ff, trailer_in;
   logic [9:0]  length_ff, length_in;
   logic [9:0]  left_ff, left_in;
   logic [11:0] msg_ff, msg_in;
   logic [15:0] good_ff, good_in;
   logic [15:0] bad_ff, bad_in;

   rsp_type out_ff, out_in, skid_ff, skid_in;
   logic    out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic        accept, pop, emit;
   rsp_type     res;
   logic [23:0] crc_upd;
   logic [9:0]  idx;
   logic [9:0]  len_full;
   logic [23:0] trailer_full;
   logic        len_err;

   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign req_tready = !skid_valid_ff;

   assign crc_upd      = crc24q_byte(crc_ff, req_tdata);
   assign idx          = length_ff - left_ff;
   assign len_full     = {length_ff[9:8], req_tdata};
   assign trailer_full = {trailer_ff[23:8], req_tdata};
   assign len_err      = ({1'b0, {1'b0, len_full} + FRAME_OVERHEAD} > {1'b0, max_frame_ff});

   // frame parser
   always_comb begin
      phase_in   = phase_ff;
      crc_in     = crc_ff;
      trailer_in = trailer_ff;
      length_in  = length_ff;
      left_in    = left_ff;
      msg_in     = msg_ff;
      good_in    = good_ff;
      bad_in     = bad_ff;
      emit       = 1'b0;
      res        = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_LEN_HI: begin
               crc_in    = crc_upd;
               length_in = {req_tdata[1:0], 8'h00};
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               crc_in    = crc_upd;
               length_in = len_full;
               left_in   = len_full;
               if (len_err) begin
                  phase_in           = PH_HUNT;
                  emit               = 1'b1;
                  res.frame_status   = STATUS_LEN_ERR;
                  res.payload_length = len_full;
                  res.computed_crc   = crc_upd;
                  res.good_frame_count = good_ff;
                  res.crc_error_count  = bad_ff;
               end else begin
                  phase_in = (len_full == 10'd0) ? PH_CRC1 : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               crc_in = crc_upd;
               if (idx == 10'd0 && length_ff >= 10'd2) begin
                  msg_in = {req_tdata, 4'h0};
               end else if (idx == 10'd1) begin
                  msg_in = {msg_ff[11:4], req_tdata[7:4]};
               end
               left_in = left_ff - 10'd1;
               if (left_ff == 10'd1) begin
                  phase_in = PH_CRC1;
               end
            end
            PH_CRC1: begin
               trailer_in = {req_tdata, 16'h0000};
               phase_in   = PH_CRC2;
            end
            PH_CRC2: begin
               trailer_in = {trailer_ff[23:16], req_tdata, 8'h00};
               phase_in   = PH_CRC3;
            end
            PH_CRC3: begin
               trailer_in = trailer_full;
               phase_in   = PH_HUNT;
               emit       = 1'b1;
               if (trailer_full == crc_ff) begin
                  good_in          = good_ff + 16'd1;
                  res.frame_status = STATUS_GOOD;
               end else begin
                  bad_in           = bad_ff + 16'd1;
                  res.frame_status = STATUS_CRC_ERR;
               end
               res.payload_length   = length_ff;
               res.message_number   = msg_ff;
               res.received_crc     = trailer_full;
               res.computed_crc     = crc_ff;
               res.good_frame_count = good_in;
               res.crc_error_count  = bad_in;
            end
            default: begin
               phase_in = PH_HUNT;
               if (req_tdata == RTCM_PREAMBLE) begin
                  crc_in     = crc24q_byte(24'h000000, req_tdata);
                  length_in  = '0;
                  left_in    = '0;
                  msg_in     = '0;
                  trailer_in = '0;
                  phase_in   = PH_LEN_HI;
               end
            end
         endcase
      end
   end

   // two-slot result buffer
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (emit) begin
         if (!out_valid_ff || pop) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff  <= MAX_FRAME_RST;
         phase_ff      <= PH_HUNT;
         crc_ff        <= '0;
         trailer_ff    <= '0;
         length_ff     <= '0;
         left_ff       <= '0;
         msg_ff        <= '0;
         good_ff       <= '0;
         bad_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            max_frame_ff <= csr_wdata;
         end
         phase_ff      <= phase_in;
         crc_ff        <= crc_in;
         trailer_ff    <= trailer_in;
         length_ff     <= length_in;
         left_ff       <= left_in;
         msg_ff        <= msg_in;
         good_ff       <= good_in;
         bad_ff        <= bad_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.frame_status;
   assign rsp_tdata  = {2'b00, out_ff.crc_error_count, out_ff.good_frame_count,
                        out_ff.computed_crc, out_ff.received_crc,
                        out_ff.message_number, out_ff.payload_length};

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("second result slot full while output slot empty");

   a_payload_left : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (left_ff != 10'd0))
      else $error("payload phase with no bytes left");

   a_one_counter : assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_CRC3) |=>
         ((good_ff != $past(good_ff)) != (bad_ff != $past(bad_ff))) && out_valid_ff)
      else $error("frame end did not bump exactly one counter with a result");

   a_len_err_hunt : assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_LEN_LO && len_err) |=>
         (phase_ff == PH_HUNT) && out_valid_ff)
      else $error("length error did not return to hunting with a result");

endmodule

`default_nettype wire
